FILE: sv/bxt_pkg.sv
// bxt_pkg: shared types and codes for the branch cross-reference table
// no dependencies
`timescale 1ns / 1ps
package bxt_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned ENTRY_W = 2 * ADDR_W + TYPE_W;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_ADD        = 3'd1,
    OP_FIND_CALLS = 3'd2,
    OP_FIND_JUMPS = 3'd3,
    OP_COUNT      = 3'd4,
    OP_SORT       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_t;

  localparam logic [TYPE_W-1:0] TYPE_CALL = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_JUMP = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_COND = 3'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] to_addr;
    logic [TYPE_W-1:0] ref_type;
  } entry_t;

  // true when entry a must go after entry b in sorted order
  function automatic logic sorts_after(entry_t a, entry_t b);
    if (a.to_addr != b.to_addr) begin
      return a.to_addr > b.to_addr;
    end
    return a.src_addr > b.src_addr;
  endfunction

endpackage

FILE: sv/bxt_ram.sv
// bxt_ram: generic single-port-write, single-read synchronous ram
// registered read; no dependencies
`timescale 1ns / 1ps
module bxt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/branch_xref_table_unit.sv
// branch_xref_table_unit: cross-reference table over one entry ram
// add/clear: result registered at the accepting edge
// find/count: scan to the final result, one ram read per entry
// sort: insertion sort, ram-port bound
// one transaction in flight; no clearing pass after reset, entry count resets to zero
// depends on bxt_pkg, bxt_ram
`timescale 1ns / 1ps
module branch_xref_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MATCH_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [31:0] src_addr,
  input  logic [31:0] to_addr,
  input  logic [2:0]  ref_type,
  input  logic [31:0] query_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] match_from,
  output logic [31:0] match_to,
  output logic [2:0]  match_type,
  output logic [10:0] ref_count,
  output logic        last
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = $clog2(MATCH_LIMIT + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [MW-1:0] LIMIT_C = MW'(MATCH_LIMIT);
  localparam logic [10:0] CNT_MAX = 11'h7ff;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END, S_SO_RDI, S_SO_WAITI, S_SO_RDJ,
    S_SO_CMP, S_SO_PUT, S_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic [CW-1:0] jdx;
  logic [MW-1:0] nmatch;
  logic [10:0] cnt;
  logic [2:0] cur_op;
  logic [31:0] q;
  bxt_pkg::entry_t key;
  logic pend_valid;
  bxt_pkg::entry_t pend;
  logic pend_done;

  logic we;
  logic [AW-1:0] waddr, raddr;
  bxt_pkg::entry_t wdata, rdata;

  bxt_ram #(.WIDTH(bxt_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic sel;
  always_comb begin
    if (cur_op == bxt_pkg::OP_FIND_CALLS) begin
      sel = rdata.ref_type == bxt_pkg::TYPE_CALL;
    end else begin
      sel = rdata.ref_type == bxt_pkg::TYPE_JUMP || rdata.ref_type == bxt_pkg::TYPE_COND;
    end
  end

  logic hit;
  assign hit = rdata.to_addr == q && sel && nmatch < LIMIT_C;

  // output register may hold a match while scan continues only when taken
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  logic out_load;
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        out_load = in_valid && in_ready &&
                   (op == bxt_pkg::OP_CLEAR || op == bxt_pkg::OP_ADD);
      end
      S_SCAN_CHK: begin
        out_load = cur_op != bxt_pkg::OP_COUNT && hit && out_free && pend_valid;
      end
      S_SCAN_END: out_load = out_free;
      S_SO_RDI: out_load = idx >= entry_count;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = key;
    raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        we = in_valid && in_ready && op == bxt_pkg::OP_ADD && entry_count < DEPTH_C;
        waddr = entry_count[AW-1:0];
        wdata = '{src_addr: src_addr, to_addr: to_addr, ref_type: ref_type};
      end
      S_SO_RDJ: raddr = AW'(jdx - CW'(1));
      S_SO_CMP: begin
        // shift the larger entry up one slot
        we = bxt_pkg::sorts_after(rdata, key);
        waddr = jdx[AW-1:0];
        wdata = rdata;
      end
      S_SO_PUT: begin
        we = 1'b1;
        waddr = jdx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_op <= op;
            q <= query_addr;
            idx <= '0;
            nmatch <= '0;
            cnt <= '0;
            status <= bxt_pkg::ST_OK;
            match_from <= '0;
            match_to <= '0;
            match_type <= '0;
            ref_count <= '0;
            last <= 1'b1;
            case (op)
              bxt_pkg::OP_CLEAR: begin
                entry_count <= '0;
              end
              bxt_pkg::OP_ADD: begin
                if (entry_count < DEPTH_C) begin
                  entry_count <= entry_count + CW'(1);
                end else begin
                  status <= bxt_pkg::ST_FULL;
                end
              end
              bxt_pkg::OP_FIND_CALLS, bxt_pkg::OP_FIND_JUMPS,
              bxt_pkg::OP_COUNT: state <= S_SCAN_RD;
              bxt_pkg::OP_SORT: begin
                idx <= CW'(1);
                state <= S_SO_RDI;
              end
              default: ;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (idx >= entry_count) begin
            state <= S_SCAN_END;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (cur_op == bxt_pkg::OP_COUNT) begin
            if (rdata.to_addr == q && cnt != CNT_MAX) begin
              cnt <= cnt + 11'd1;
            end
            idx <= idx + CW'(1);
            state <= S_SCAN_RD;
          end else if (hit) begin
            // hold the match one step so the final one can be flagged
            if (out_free) begin
              if (pend_valid) begin
                status <= bxt_pkg::ST_OK;
                match_from <= pend.src_addr;
                match_to <= pend.to_addr;
                match_type <= pend.ref_type;
                last <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend <= rdata;
              nmatch <= nmatch + MW'(1);
              idx <= idx + CW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_END: begin
          if (out_free) begin
            last <= 1'b1;
            pend_valid <= 1'b0;
            status <= bxt_pkg::ST_OK;
            if (cur_op == bxt_pkg::OP_COUNT) begin
              ref_count <= cnt;
            end else if (pend_valid) begin
              match_from <= pend.src_addr;
              match_to <= pend.to_addr;
              match_type <= pend.ref_type;
            end else begin
              status <= bxt_pkg::ST_NO_MATCH;
              match_from <= '0;
              match_to <= '0;
              match_type <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_SO_RDI: begin
          if (idx >= entry_count) begin
            state <= S_OUT;
          end else begin
            jdx <= idx;
            state <= S_SO_WAITI;
          end
        end
        S_SO_WAITI: begin
          state <= S_SO_RDJ;
        end
        S_SO_RDJ: begin
          if (pend_done == 1'b0) begin
            key <= rdata;
            pend_done <= 1'b1;
          end
          if (jdx == '0) begin
            state <= S_SO_PUT;
          end else begin
            state <= S_SO_CMP;
          end
        end
        S_SO_CMP: begin
          if (bxt_pkg::sorts_after(rdata, key)) begin
            jdx <= jdx - CW'(1);
            state <= S_SO_RDJ;
          end else begin
            state <= S_SO_PUT;
          end
        end
        S_SO_PUT: begin
          pend_done <= 1'b0;
          idx <= idx + CW'(1);
          state <= S_SO_RDI;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
    if (rst) begin
      pend_valid <= 1'b0;
      pend_done <= 1'b0;
    end
  end

endmodule

FILE: tb/branch_xref_table_unit_tb.sv
// branch_xref_table_unit_tb: random and directed test of the cross-reference table
// scoreboard class predicts results of every accepted transaction; depends on bxt_pkg, branch_xref_table_unit
`timescale 1ns / 1ps
module branch_xref_table_unit_tb;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned LIMIT = 64;

  typedef struct {
    bxt_pkg::status_t status;
    logic [31:0]      src_addr;
    logic [31:0]      to_addr;
    logic [2:0]       ref_type;
    logic [10:0]      ref_count;
    logic             last;
  } xref_result_t;

  class xref_scoreboard;
    logic [31:0]  src_mem[DEPTH];
    logic [31:0]  dst_mem[DEPTH];
    logic [2:0]   kind_mem[DEPTH];
    int unsigned  used;
    xref_result_t expected_q[$];
    int unsigned  mismatches;

    function void push(bxt_pkg::status_t st, logic [31:0] f, logic [31:0] t,
                       logic [2:0] k, logic [10:0] c, logic l);
      xref_result_t r;
      r.status = st;
      r.src_addr = f;
      r.to_addr = t;
      r.ref_type = k;
      r.ref_count = c;
      r.last = l;
      expected_q.push_back(r);
    endfunction

    function void find_refs(logic [31:0] q, bit calls);
      int n;
      bit hit;
      n = 0;
      for (int i = 0; i < used; i++) begin
        hit = calls ? (kind_mem[i] == bxt_pkg::TYPE_CALL)
                    : (kind_mem[i] == bxt_pkg::TYPE_JUMP ||
                       kind_mem[i] == bxt_pkg::TYPE_COND);
        if (dst_mem[i] == q && hit && n < LIMIT) begin
          push(bxt_pkg::ST_OK, src_mem[i], dst_mem[i], kind_mem[i], '0, 1'b0);
          n++;
        end
      end
      if (n == 0) begin
        push(bxt_pkg::ST_NO_MATCH, '0, '0, '0, '0, 1'b1);
      end else begin
        expected_q[expected_q.size() - 1].last = 1'b1;
      end
    endfunction

    function void sort_table();
      logic [31:0] f;
      logic [31:0] t;
      logic [2:0]  k;
      int j;
      for (int i = 1; i < used; i++) begin
        f = src_mem[i];
        t = dst_mem[i];
        k = kind_mem[i];
        j = i;
        while (j > 0 && (dst_mem[j-1] > t || (dst_mem[j-1] == t && src_mem[j-1] > f))) begin
          src_mem[j] = src_mem[j-1];
          dst_mem[j] = dst_mem[j-1];
          kind_mem[j] = kind_mem[j-1];
          j--;
        end
        src_mem[j] = f;
        dst_mem[j] = t;
        kind_mem[j] = k;
      end
    endfunction

    function void note_input(logic [2:0] op, logic [31:0] f, logic [31:0] t,
                             logic [2:0] k, logic [31:0] q);
      int unsigned cnt;
      case (op)
        bxt_pkg::OP_CLEAR: begin
          used = 0;
          push(bxt_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
        end
        bxt_pkg::OP_ADD: begin
          if (used >= DEPTH) begin
            push(bxt_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          end else begin
            src_mem[used] = f;
            dst_mem[used] = t;
            kind_mem[used] = k;
            used++;
            push(bxt_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
          end
        end
        bxt_pkg::OP_FIND_CALLS: find_refs(q, 1'b1);
        bxt_pkg::OP_FIND_JUMPS: find_refs(q, 1'b0);
        bxt_pkg::OP_COUNT: begin
          cnt = 0;
          for (int i = 0; i < used; i++) begin
            if (dst_mem[i] == q && cnt < 2047) cnt++;
          end
          push(bxt_pkg::ST_OK, '0, '0, '0, cnt[10:0], 1'b1);
        end
        bxt_pkg::OP_SORT: begin
          sort_table();
          push(bxt_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] f, logic [31:0] t,
                               logic [2:0] k, logic [10:0] c, logic l);
      xref_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction status=%0d", st);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || f !== e.src_addr || t !== e.to_addr || k !== e.ref_type ||
          c !== e.ref_count || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp st=%0d from=%h to=%h type=%0d cnt=%0d last=%0d",
                   e.status, e.src_addr, e.to_addr, e.ref_type, e.ref_count, e.last);
          $display("         got st=%0d from=%h to=%h type=%0d cnt=%0d last=%0d",
                   st, f, t, k, c, l);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  op;
  logic [31:0] src_addr;
  logic [31:0] to_addr;
  logic [2:0]  ref_type;
  logic [31:0] query_addr;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] match_from;
  logic [31:0] match_to;
  logic [2:0]  match_type;
  logic [10:0] ref_count;
  logic        last;

  xref_scoreboard sb;
  bit             no_idle;
  int             out_stall;
  logic [31:0]    addr_pool[4];

  branch_xref_table_unit #(
    .TABLE_DEPTH(DEPTH),
    .MATCH_LIMIT(LIMIT)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .src_addr(src_addr), .to_addr(to_addr),
    .ref_type(ref_type), .query_addr(query_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .match_from(match_from), .match_to(match_to),
    .match_type(match_type), .ref_count(ref_count), .last(last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(op, src_addr, to_addr, ref_type, query_addr);
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(status, match_from, match_to, match_type, ref_count, last);
        out_stall = no_idle ? 0 : $urandom_range(0, 10);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  task automatic send_item(logic [2:0] o, logic [31:0] f, logic [31:0] t,
                           logic [2:0] k, logic [31:0] q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    src_addr <= f;
    to_addr <= t;
    ref_type <= k;
    query_addr <= q;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) < 8) return addr_pool[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  task automatic random_item();
    int unsigned w;
    logic [2:0] o;
    w = $urandom_range(0, 99);
    if (w < 50) o = bxt_pkg::OP_ADD;
    else if (w < 62) o = bxt_pkg::OP_FIND_CALLS;
    else if (w < 74) o = bxt_pkg::OP_FIND_JUMPS;
    else if (w < 84) o = bxt_pkg::OP_COUNT;
    else if (w < 92) o = bxt_pkg::OP_SORT;
    else if (w < 96) o = bxt_pkg::OP_CLEAR;
    else o = 3'($urandom_range(6, 7));
    send_item(o, pick_addr(), pick_addr(), 3'($urandom_range(0, 7)), pick_addr());
  endtask

  initial begin
    logic [31:0] x;
    int waited;
    sb = new();
    no_idle = 1'b0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = $urandom();
    addr_pool[3] = $urandom();
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= bxt_pkg::OP_CLEAR;
    src_addr <= '0;
    to_addr <= '0;
    ref_type <= '0;
    query_addr <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    x = addr_pool[2];
    send_item(bxt_pkg::OP_FIND_CALLS, '0, '0, '0, x);
    send_item(bxt_pkg::OP_COUNT, '0, '0, '0, x);
    send_item(bxt_pkg::OP_ADD, 32'hFFFF_FFFF, x, bxt_pkg::TYPE_CALL, '0);
    send_item(bxt_pkg::OP_ADD, 32'h0000_0000, x, bxt_pkg::TYPE_CALL, '0);
    send_item(bxt_pkg::OP_ADD, 32'h5555_5555, x, bxt_pkg::TYPE_CALL, '0);
    send_item(bxt_pkg::OP_ADD, 32'hAAAA_AAAA, x, bxt_pkg::TYPE_CALL, '0);
    send_item(bxt_pkg::OP_ADD, 32'h1234_5678, x, bxt_pkg::TYPE_CALL, '0);
    for (int k = 1; k < 8; k++) send_item(bxt_pkg::OP_ADD, $urandom(), x, 3'(k), '0);
    send_item(bxt_pkg::OP_FIND_CALLS, '0, '0, '0, x);
    send_item(bxt_pkg::OP_FIND_JUMPS, '0, '0, '0, x);
    send_item(bxt_pkg::OP_COUNT, '0, '0, '0, x);
    send_item(bxt_pkg::OP_FIND_JUMPS, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(bxt_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, bxt_pkg::TYPE_JUMP, '0);
    send_item(bxt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0, bxt_pkg::TYPE_COND, '0);
    send_item(bxt_pkg::OP_ADD, 32'h0, 32'h0, bxt_pkg::TYPE_CALL, '0);
    send_item(bxt_pkg::OP_ADD, 32'h7, 32'h0, bxt_pkg::TYPE_CALL, '0);
    send_item(bxt_pkg::OP_ADD, 32'h9, 32'h1, bxt_pkg::TYPE_JUMP, '0);
    send_item(bxt_pkg::OP_SORT, '0, '0, '0, '0);
    send_item(bxt_pkg::OP_FIND_CALLS, '0, '0, '0, x);
    send_item(3'd6, $urandom(), $urandom(), 3'd1, x);
    send_item(3'd7, $urandom(), $urandom(), 3'd1, x);
    send_item(bxt_pkg::OP_CLEAR, '0, '0, '0, '0);

    for (int n = 0; n < 80; n++) begin
      no_idle = (n >= 40 && n < 60);
      random_item();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
